FILE: rtl/core/drd_pkg.sv
// ----------------------------------------------------------------------------
// drd_pkg - shared types and constants for the detector row decoder
// Row record, result record, config bundle and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package drd_pkg;

	// largest number of class scores in one row
	localparam int MAX_CLASSES = 128;

	localparam int VAL_W   = 24;  // Q12.12 element
	localparam int CLS_W   = 7;   // class id field
	localparam int CONF_W  = 23;  // confidence field
	localparam int COORD_W = 16;  // box coordinate fields
	localparam int IDX_W   = 16;  // row counter

	// element position covers box, objectness and all class scores
	localparam int POS_W = $clog2(MAX_CLASSES + 6);
	// compare width wide enough for both the position and class_count
	localparam int CMP_W = (POS_W > 8) ? POS_W : 8;

	localparam int POS_OBJ       = 4;  // objectness position
	localparam int POS_FIRST_CLS = 5;  // first class score position

	// config register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLASS_COUNT = 3'd0,
		REG_OBJ_THR     = 3'd1,
		REG_CLS_THR     = 3'd2,
		REG_X_SCALE     = 3'd3,
		REG_Y_SCALE     = 3'd4
	} cfg_reg_t;
	localparam int CFG_DATA_W = 16;

	localparam logic [7:0]  RST_CLASS_COUNT = 8'd80;
	localparam logic [12:0] RST_OBJ_THR     = 13'd1024;
	localparam logic [12:0] RST_CLS_THR     = 13'd1024;
	localparam logic [15:0] RST_X_SCALE     = 16'd4096;
	localparam logic [15:0] RST_Y_SCALE     = 16'd4096;

	typedef struct packed {
		logic [7:0]  class_count;
		logic [12:0] obj_thr;
		logic [12:0] cls_thr;
		logic [15:0] x_scale;
		logic [15:0] y_scale;
	} cfg_t;

	// a finished, accepted row
	typedef struct packed {
		logic [CLS_W-1:0]        class_id;
		logic signed [VAL_W-1:0] objectness;
		logic signed [VAL_W-1:0] box_x;
		logic signed [VAL_W-1:0] box_y;
		logic signed [VAL_W-1:0] box_w;
		logic signed [VAL_W-1:0] box_h;
		logic [IDX_W-1:0]        index;
	} row_rec_t;

	// result beat payload; last member lands in the lowest bits
	typedef struct packed {
		logic [IDX_W-1:0]   candidate_index;
		logic [COORD_W-1:0] box_height;
		logic [COORD_W-1:0] box_width;
		logic [COORD_W-1:0] box_top;
		logic [COORD_W-1:0] box_left;
		logic [CONF_W-1:0]  confidence;
		logic [CLS_W-1:0]   class_id;
	} result_t;

	localparam int RES_W    = $bits(result_t);
	localparam int OUT_W    = ((RES_W + 7) / 8) * 8;
	localparam int OUT_PAD  = OUT_W - RES_W;

	// output queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [QCNT_W-1:0] count;
	} q_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/drd_row_track.sv
// ----------------------------------------------------------------------------
// drd_row_track - row element tracker
// Input register, box/objectness capture, running argmax, row completion.
// ----------------------------------------------------------------------------
`default_nettype none

module drd_row_track (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire drd_pkg::cfg_t              cfg,
	input  wire                             in_valid,
	input  wire logic signed [drd_pkg::VAL_W-1:0] in_value,
	input  wire                             in_start,
	output logic                            valid_s1,
	output logic                            rec_valid,
	output drd_pkg::row_rec_t               rec
);

	logic signed [drd_pkg::VAL_W-1:0] value_s1;
	logic                             start_s1;

	logic [drd_pkg::POS_W-1:0]        pos_q;
	logic signed [drd_pkg::VAL_W-1:0] box_q [4];
	logic signed [drd_pkg::VAL_W-1:0] obj_q;
	logic signed [drd_pkg::VAL_W-1:0] best_q;
	logic [drd_pkg::CLS_W-1:0]        best_cls_q;
	logic [drd_pkg::IDX_W-1:0]        row_cnt_q;

	logic [drd_pkg::CMP_W-1:0]        ncls;
	logic [drd_pkg::CMP_W-1:0]        last_pos;
	logic [drd_pkg::CMP_W-1:0]        pos;
	logic [drd_pkg::CMP_W-1:0]        cls_off;
	logic                             take_best;
	logic signed [drd_pkg::VAL_W-1:0] best_nxt;
	logic [drd_pkg::CLS_W-1:0]        cls_nxt;
	logic                             row_done;
	logic                             keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			value_s1 <= in_value;
			start_s1 <= in_start;
		end
	end

	always_comb begin
		// class_count of zero acts as one, above the maximum as the maximum
		if (cfg.class_count == 8'd0)
			ncls = drd_pkg::CMP_W'(1);
		else if (drd_pkg::CMP_W'(cfg.class_count) > drd_pkg::CMP_W'(drd_pkg::MAX_CLASSES))
			ncls = drd_pkg::CMP_W'(drd_pkg::MAX_CLASSES);
		else
			ncls = drd_pkg::CMP_W'(cfg.class_count);
		last_pos  = ncls + drd_pkg::CMP_W'(drd_pkg::POS_OBJ);
		pos       = start_s1 ? '0 : drd_pkg::CMP_W'(pos_q);
		cls_off   = pos - drd_pkg::CMP_W'(drd_pkg::POS_FIRST_CLS);
		take_best = (pos == drd_pkg::CMP_W'(drd_pkg::POS_FIRST_CLS)) || (value_s1 > best_q);
		best_nxt  = take_best ? value_s1 : best_q;
		cls_nxt   = take_best ? cls_off[drd_pkg::CLS_W-1:0] : best_cls_q;
		// position past the last score (class_count shrunk) also completes
		row_done  = (pos >= drd_pkg::CMP_W'(drd_pkg::POS_FIRST_CLS)) && !(pos < last_pos);
		keep      = (obj_q >= $signed({11'd0, cfg.obj_thr}))
		            && (best_nxt > $signed({11'd0, cfg.cls_thr}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			box_q[0]   <= '0;
			box_q[1]   <= '0;
			box_q[2]   <= '0;
			box_q[3]   <= '0;
			obj_q      <= '0;
			best_q     <= '0;
			best_cls_q <= '0;
			row_cnt_q  <= '0;
			rec_valid  <= 1'b0;
		end else begin
			rec_valid <= 1'b0;
			if (valid_s1) begin
				if (pos < drd_pkg::CMP_W'(drd_pkg::POS_OBJ)) begin
					box_q[pos[1:0]] <= value_s1;
					pos_q           <= drd_pkg::POS_W'(pos + 1'b1);
				end else if (pos == drd_pkg::CMP_W'(drd_pkg::POS_OBJ)) begin
					obj_q <= value_s1;
					pos_q <= drd_pkg::POS_W'(drd_pkg::POS_FIRST_CLS);
				end else begin
					best_q     <= best_nxt;
					best_cls_q <= cls_nxt;
					if (row_done) begin
						pos_q     <= '0;
						row_cnt_q <= row_cnt_q + 1'b1;
						rec_valid <= keep;
					end else begin
						pos_q <= drd_pkg::POS_W'(pos + 1'b1);
					end
				end
			end
		end
	end

	// row record, loaded only on completion
	always_ff @(posedge clk) begin
		if (valid_s1 && row_done) begin
			rec.class_id   <= cls_nxt;
			rec.objectness <= obj_q;
			rec.box_x      <= box_q[0];
			rec.box_y      <= box_q[1];
			rec.box_w      <= box_q[2];
			rec.box_h      <= box_q[3];
			rec.index      <= row_cnt_q;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/drd_box_scale.sv
// ----------------------------------------------------------------------------
// drd_box_scale - box scaling to image pixels
// Product stage, then truncate toward zero and saturate to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module drd_box_scale (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire drd_pkg::cfg_t     cfg,
	input  wire                    rec_valid,
	input  wire drd_pkg::row_rec_t rec,
	output logic                   res_valid,
	output drd_pkg::result_t       res
);

	localparam int PW = 43;

	logic signed [PW-1:0] dx_ext, dy_ext, w_ext, h_ext, sx_ext, sy_ext;

	logic signed [PW-1:0] p_left_s3, p_top_s3, p_width_s3, p_height_s3;
	logic [drd_pkg::CLS_W-1:0]  cls_s3;
	logic [drd_pkg::CONF_W-1:0] conf_s3;
	logic [drd_pkg::IDX_W-1:0]  idx_s3;

	function automatic logic [drd_pkg::COORD_W-1:0] trunc_sat(
		input logic signed [PW-1:0] n,
		input int                   sh
	);
		logic signed [PW-1:0] q;
		logic [PW-1:0]        mask;
		begin
			mask = (PW'(1) << sh) - PW'(1);
			q    = n >>> sh;
			// arithmetic shift floors; nudge negatives back toward zero
			if (n[PW-1] && ((n & mask) != '0))
				q = q + PW'(1);
			if (q > PW'(32767))
				trunc_sat = 16'h7FFF;
			else if (q < -PW'(32768))
				trunc_sat = 16'h8000;
			else
				trunc_sat = q[drd_pkg::COORD_W-1:0];
		end
	endfunction

	always_comb begin
		// 2x - w and 2y - h, exact
		dx_ext = ({{(PW-drd_pkg::VAL_W){rec.box_x[drd_pkg::VAL_W-1]}}, rec.box_x} <<< 1)
		         - {{(PW-drd_pkg::VAL_W){rec.box_w[drd_pkg::VAL_W-1]}}, rec.box_w};
		dy_ext = ({{(PW-drd_pkg::VAL_W){rec.box_y[drd_pkg::VAL_W-1]}}, rec.box_y} <<< 1)
		         - {{(PW-drd_pkg::VAL_W){rec.box_h[drd_pkg::VAL_W-1]}}, rec.box_h};
		w_ext  = {{(PW-drd_pkg::VAL_W){rec.box_w[drd_pkg::VAL_W-1]}}, rec.box_w};
		h_ext  = {{(PW-drd_pkg::VAL_W){rec.box_h[drd_pkg::VAL_W-1]}}, rec.box_h};
		sx_ext = {{(PW-16){1'b0}}, cfg.x_scale};
		sy_ext = {{(PW-16){1'b0}}, cfg.y_scale};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else begin
			res_valid <= rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_valid) begin
			p_left_s3   <= dx_ext * sx_ext;
			p_top_s3    <= dy_ext * sy_ext;
			p_width_s3  <= w_ext * sx_ext;
			p_height_s3 <= h_ext * sy_ext;
			cls_s3      <= rec.class_id;
			conf_s3     <= rec.objectness[drd_pkg::CONF_W-1:0];
			idx_s3      <= rec.index;
		end
	end

	always_comb begin
		res.class_id        = cls_s3;
		res.confidence      = conf_s3;
		res.box_left        = trunc_sat(p_left_s3, 25);
		res.box_top         = trunc_sat(p_top_s3, 25);
		res.box_width       = trunc_sat(p_width_s3, 24);
		res.box_height      = trunc_sat(p_height_s3, 24);
		res.candidate_index = idx_s3;
	end

endmodule

`default_nettype wire

FILE: rtl/core/drd_out_queue.sv
// ----------------------------------------------------------------------------
// drd_out_queue - result queue
// Small register FIFO holding finished results for the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module drd_out_queue (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    push,
	input  wire drd_pkg::result_t  push_data,
	output logic                   m_tvalid,
	input  wire                    m_tready,
	output drd_pkg::result_t       head,
	output drd_pkg::q_status_t     status
);

	drd_pkg::result_t            mem_q [drd_pkg::QUEUE_DEPTH];
	logic [drd_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [drd_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [drd_pkg::QCNT_W-1:0]  count_q;
	logic                        pop;

	assign m_tvalid     = (count_q != '0);
	assign pop          = m_tvalid && m_tready;
	assign head         = mem_q[rd_ptr_q];
	assign status.count = count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == drd_pkg::QPTR_W'(drd_pkg::QUEUE_DEPTH - 1))
				            ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == drd_pkg::QPTR_W'(drd_pkg::QUEUE_DEPTH - 1))
				            ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/detector_row_decode_core.sv
// ----------------------------------------------------------------------------
// detector_row_decode_core - detector output row decoder
// Takes one row element per beat, emits a scaled candidate box per kept row.
// ----------------------------------------------------------------------------
// A row is box x, y, w, h, objectness, then class_count class scores, each a
// signed Q12.12 element on its own input beat; s_tuser marks box x of a new
// row (a partial row is then dropped). One element is taken every cycle
// while s_tready is high. A candidate beat follows the last score of a row
// when objectness is at least the objectness threshold and the best score
// (first maximum wins) exceeds the class threshold; it leaves on m_tdata
// after the input register, row record, multiply and queue. Rejected rows
// still advance candidate_index. Results wait in a 4-deep queue; s_tready
// drops only while that queue plus the results that may still be in flight
// would fill it, so input stalls appear only under sustained output
// backpressure. Config writes take effect at once and are meant for idle
// periods. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module detector_row_decode_core (
	input  wire                               clk,
	input  wire                               arst_n,
	// element stream
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire [23:0]                        s_tdata,    // [23:0] element_value
	input  wire [0:0]                         s_tuser,    // [0] row_start
	// candidate stream
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// [6:0] class_id, [29:7] confidence, [45:30] box_left, [61:46] box_top,
	// [77:62] box_width, [93:78] box_height, [109:94] candidate_index,
	// [111:110] zero
	output logic [drd_pkg::OUT_W-1:0]         m_tdata,
	// config write port
	input  wire                               cfg_wr_en,
	input  wire [drd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [drd_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

	drd_pkg::cfg_t       cfg_q;
	logic                in_accept;
	logic                valid_s1;
	logic                rec_valid;
	drd_pkg::row_rec_t   rec;
	logic                res_valid;
	drd_pkg::result_t    res;
	drd_pkg::result_t    head;
	drd_pkg::q_status_t  q_stat;
	logic [drd_pkg::QCNT_W:0] committed;

	// ---- config registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.class_count <= drd_pkg::RST_CLASS_COUNT;
			cfg_q.obj_thr     <= drd_pkg::RST_OBJ_THR;
			cfg_q.cls_thr     <= drd_pkg::RST_CLS_THR;
			cfg_q.x_scale     <= drd_pkg::RST_X_SCALE;
			cfg_q.y_scale     <= drd_pkg::RST_Y_SCALE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				drd_pkg::REG_CLASS_COUNT: cfg_q.class_count <= cfg_wr_data[7:0];
				drd_pkg::REG_OBJ_THR:     cfg_q.obj_thr     <= cfg_wr_data[12:0];
				drd_pkg::REG_CLS_THR:     cfg_q.cls_thr     <= cfg_wr_data[12:0];
				drd_pkg::REG_X_SCALE:     cfg_q.x_scale     <= cfg_wr_data[15:0];
				drd_pkg::REG_Y_SCALE:     cfg_q.y_scale     <= cfg_wr_data[15:0];
				default: ;  // unmapped index, ignored
			endcase
		end
	end

	// ---- input flow control ----
	// Every stage that could still turn into a queue entry is counted, so a
	// beat is only taken when the queue is sure to have room for it.
	assign committed = (drd_pkg::QCNT_W+1)'(q_stat.count)
	                 + (drd_pkg::QCNT_W+1)'(valid_s1)
	                 + (drd_pkg::QCNT_W+1)'(rec_valid)
	                 + (drd_pkg::QCNT_W+1)'(res_valid);
	assign s_tready  = (committed < (drd_pkg::QCNT_W+1)'(drd_pkg::QUEUE_DEPTH));
	assign in_accept = s_tvalid && s_tready;

	// ---- row tracking: input register, argmax, row completion ----
	drd_row_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_accept),
		.in_value  (s_tdata),
		.in_start  (s_tuser[0]),
		.valid_s1  (valid_s1),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	// ---- box scaling ----
	drd_box_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.rec_valid (rec_valid),
		.rec       (rec),
		.res_valid (res_valid),
		.res       (res)
	);

	// ---- output queue ----
	drd_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.head      (head),
		.status    (q_stat)
	);

	assign m_tdata = {{drd_pkg::OUT_PAD{1'b0}}, head};

`ifndef NO_ASSERTIONS
	// a row record only follows an element held in the input register
	a_rec_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> $past(valid_s1))
		else $error("row record without a preceding element");

	// every row record reaches the queue in the following cycle
	a_rec_to_res: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |=> res_valid)
		else $error("row record lost in scaling stage");

	// flow control must keep the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (q_stat.count < drd_pkg::QCNT_W'(drd_pkg::QUEUE_DEPTH)))
		else $error("result pushed into a full queue");
`endif

endmodule

`default_nettype wire
